// ----- src/tcc_pkg.sv -----
package tcc_pkg;

  // Register file and field widths
  localparam int NUM_LEVELS = 5;
  localparam int TIME_W     = 14;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int MSG_W      = 4;
  localparam int SEG_W      = 32;

  // Register indexes
  localparam logic [2:0] REG_LEVEL_ONE   = 3'd0;
  localparam logic [2:0] REG_LEVEL_TWO   = 3'd1;
  localparam logic [2:0] REG_LEVEL_THREE = 3'd2;
  localparam logic [2:0] REG_LEVEL_FOUR  = 3'd3;
  localparam logic [2:0] REG_LEVEL_FIVE  = 3'd4;

  // Reset values of the level times
  localparam logic [TIME_W-1:0] LEVEL_TIME_RST [NUM_LEVELS] = '{
    14'd12, 14'd25, 14'd40, 14'd60, 14'd70
  };

  // Event kinds
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SWITCH = 2'd1;
  localparam logic [1:0] CMD_KEY    = 2'd2;

  // Keys
  localparam logic [1:0] KEY_START = 2'd0;
  localparam logic [1:0] KEY_STOP  = 2'd1;
  localparam logic [1:0] KEY_PAUSE = 2'd2;

  // First level that runs without a timer
  localparam logic [2:0] LEVEL_CONT = 3'd6;

  // Status messages
  localparam logic [MSG_W-1:0] MSG_IDLE     = 4'd0;
  localparam logic [MSG_W-1:0] MSG_TOASTING = 4'd1;
  localparam logic [MSG_W-1:0] MSG_STOPPED  = 4'd2;
  localparam logic [MSG_W-1:0] MSG_PAUSED   = 4'd3;
  localparam logic [MSG_W-1:0] MSG_BURNT    = 4'd4;
  localparam logic [MSG_W-1:0] MSG_OVERHEAT = 4'd5;
  localparam logic [MSG_W-1:0] MSG_ERROR    = 4'd6;
  localparam logic [MSG_W-1:0] MSG_NOBREAD  = 4'd7;
  localparam logic [MSG_W-1:0] MSG_FINISHED = 4'd8;

  // Reciprocal of ten, exact for values below 2^14
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Result of one event, before display conversion
  typedef struct packed {
    logic              heater;
    logic              eject;
    logic              run;
    logic              toast;
    logic [MSG_W-1:0]  message;
    logic [TIME_W-1:0] remaining;
  } res_t;

  // Quotient by ten
  function automatic logic [10:0] div10(input logic [TIME_W-1:0] v);
    logic [29:0] p;
    p = 30'(v) * 30'(DIV10_MUL);
    return p[DIV10_SHIFT +: 11];
  endfunction

  // Remainder by ten, given the quotient
  function automatic logic [3:0] rem10(input logic [TIME_W-1:0] v, input logic [10:0] q);
    logic [TIME_W-1:0] r;
    r = v - (TIME_W'(q) << 3) - (TIME_W'(q) << 1);
    return r[3:0];
  endfunction

  // Seven-segment pattern of one decimal digit
  function automatic logic [7:0] seg7(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- src/toast_cycle_controller.sv -----
// Toaster cycle controller. Each input beat is one event (one-second tick,
// switch update or key press); each produces exactly one result beat with
// heater/eject drives, run/toast flags, message code, remaining seconds and
// four seven-segment digits. The cycle state is updated at the edge the event
// is accepted, so a new event can be taken every clock unless the result
// channel stalls. The decimal split of the remaining count goes
// through three register stages, one divide-by-ten per stage, the last of them
// being the output register. Level times live in five APB registers at byte
// addresses 0x0..0x10; write them only while no beat is in flight.
module toast_cycle_controller (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0]        paddr,
  input  logic [tcc_pkg::DATA_W-1:0]        pwdata,
  output logic [tcc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // event channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic [2:0]                        level,
  input  logic                              bread_present,
  input  logic                              fault_error,
  input  logic                              overheat,
  input  logic                              burnt,
  input  logic [1:0]                        key,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              heater_on,
  output logic                              eject_on,
  output logic                              running,
  output logic                              toasting,
  output logic [tcc_pkg::MSG_W-1:0]         message,
  output logic [tcc_pkg::TIME_W-1:0]        remaining,
  output logic [tcc_pkg::SEG_W-1:0]         segments
);
  import tcc_pkg::*;

  // configuration registers
  logic [TIME_W-1:0] level_time [NUM_LEVELS];

  // cycle state
  logic              run_flag, stop_flag, toast_flag, resume_flag;
  logic [TIME_W-1:0] count_left, cycle_time;
  logic [2:0]        level_held;
  logic [3:0]        sensors_held;
  logic              heater_reg, eject_reg;
  logic [MSG_W-1:0]  message_reg;

  logic              run_flag_next, stop_flag_next, toast_flag_next, resume_flag_next;
  logic [TIME_W-1:0] count_left_next, cycle_time_next;
  logic [2:0]        level_held_next;
  logic [3:0]        sensors_held_next;
  logic              heater_reg_next, eject_reg_next;
  logic [MSG_W-1:0]  message_reg_next;
  logic              cont_next;

  // pipeline
  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3, out_free;
  logic        accept;
  res_t        s1_res, s2_res, s3_res;
  logic [10:0] s2_q;
  logic [7:0]  s3_q;
  logic [3:0]  s2_d0, s3_d0, s3_d1;
  logic [10:0] q1, q2, q3;
  logic [3:0]  d3;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // APB access
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) level_time[i] <= LEVEL_TIME_RST[i];
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LEVEL_ONE:   level_time[0] <= pwdata[TIME_W-1:0];
        REG_LEVEL_TWO:   level_time[1] <= pwdata[TIME_W-1:0];
        REG_LEVEL_THREE: level_time[2] <= pwdata[TIME_W-1:0];
        REG_LEVEL_FOUR:  level_time[3] <= pwdata[TIME_W-1:0];
        REG_LEVEL_FIVE:  level_time[4] <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LEVEL_ONE:   prdata = DATA_W'(level_time[0]);
      REG_LEVEL_TWO:   prdata = DATA_W'(level_time[1]);
      REG_LEVEL_THREE: prdata = DATA_W'(level_time[2]);
      REG_LEVEL_FOUR:  prdata = DATA_W'(level_time[3]);
      REG_LEVEL_FIVE:  prdata = DATA_W'(level_time[4]);
      default:         prdata = '0;
    endcase
  end

  // handshake: each stage moves when the one after it has room
  assign out_free = ~out_valid | out_ready;
  assign rdy3     = ~v3 | out_free;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid & in_ready;

  // event handling and sensor check
  always_comb begin
    run_flag_next     = run_flag;
    stop_flag_next    = stop_flag;
    toast_flag_next   = toast_flag;
    resume_flag_next  = resume_flag;
    count_left_next   = count_left;
    cycle_time_next   = cycle_time;
    level_held_next   = level_held;
    sensors_held_next = sensors_held;
    heater_reg_next   = heater_reg;
    eject_reg_next    = eject_reg;
    message_reg_next  = message_reg;

    unique case (command)
      CMD_TICK: begin
        if (toast_flag && level_held < LEVEL_CONT && count_left != '0)
          count_left_next = count_left - 1'b1;
      end
      CMD_SWITCH: begin
        sensors_held_next = {burnt, overheat, fault_error, bread_present};
        if (level != level_held) begin
          level_held_next = level;
          case (level)
            3'd1:    cycle_time_next = level_time[0];
            3'd2:    cycle_time_next = level_time[1];
            3'd3:    cycle_time_next = level_time[2];
            3'd4:    cycle_time_next = level_time[3];
            3'd5:    cycle_time_next = level_time[4];
            default: cycle_time_next = '0;
          endcase
        end
      end
      CMD_KEY: begin
        unique case (key)
          KEY_START: begin
            if (sensors_held[0] && !sensors_held[1] && !sensors_held[2] &&
                level_held != 3'd0) begin
              run_flag_next    = 1'b1;
              stop_flag_next   = 1'b0;
              toast_flag_next  = 1'b1;
              count_left_next  = (level_held >= LEVEL_CONT) ? '0 : cycle_time;
              heater_reg_next  = 1'b1;
              eject_reg_next   = 1'b0;
              message_reg_next = MSG_TOASTING;
            end
          end
          KEY_STOP: begin
            run_flag_next    = 1'b0;
            stop_flag_next   = 1'b1;
            toast_flag_next  = 1'b0;
            heater_reg_next  = 1'b0;
            count_left_next  = '0;
            eject_reg_next   = 1'b1;
            message_reg_next = MSG_STOPPED;
          end
          KEY_PAUSE: begin
            run_flag_next  = 1'b1;
            stop_flag_next = 1'b0;
            if (toast_flag) begin
              toast_flag_next  = 1'b0;
              resume_flag_next = 1'b0;
              heater_reg_next  = 1'b0;
              message_reg_next = MSG_PAUSED;
            end else begin
              toast_flag_next  = 1'b1;
              resume_flag_next = 1'b1;
              heater_reg_next  = 1'b1;
              message_reg_next = MSG_TOASTING;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // sensor faults end a cycle; a timed cycle at zero finishes
    cont_next = (level_held_next >= LEVEL_CONT);
    if (run_flag_next) begin
      if (!sensors_held_next[0] || sensors_held_next[3:1] != 3'b000) begin
        run_flag_next   = 1'b0;
        stop_flag_next  = 1'b1;
        toast_flag_next = 1'b0;
        heater_reg_next = 1'b0;
        eject_reg_next  = 1'b1;
        if (sensors_held_next[3])      message_reg_next = MSG_BURNT;
        else if (sensors_held_next[2]) message_reg_next = MSG_OVERHEAT;
        else if (sensors_held_next[1]) message_reg_next = MSG_ERROR;
        else                           message_reg_next = MSG_NOBREAD;
      end else if (count_left_next == '0 && !cont_next) begin
        run_flag_next    = 1'b0;
        stop_flag_next   = 1'b1;
        toast_flag_next  = 1'b0;
        heater_reg_next  = 1'b0;
        message_reg_next = MSG_FINISHED;
      end
    end
  end

  // state registers, updated per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag     <= 1'b0;
      stop_flag    <= 1'b1;
      toast_flag   <= 1'b0;
      resume_flag  <= 1'b0;
      count_left   <= '0;
      cycle_time   <= '0;
      level_held   <= '0;
      sensors_held <= '0;
      heater_reg   <= 1'b0;
      eject_reg    <= 1'b0;
      message_reg  <= MSG_IDLE;
    end else if (accept) begin
      run_flag     <= run_flag_next;
      stop_flag    <= stop_flag_next;
      toast_flag   <= toast_flag_next;
      resume_flag  <= resume_flag_next;
      count_left   <= count_left_next;
      cycle_time   <= cycle_time_next;
      level_held   <= level_held_next;
      sensors_held <= sensors_held_next;
      heater_reg   <= heater_reg_next;
      eject_reg    <= eject_reg_next;
      message_reg  <= message_reg_next;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)     v1        <= in_valid;
      if (rdy2)     v2        <= v1;
      if (rdy3)     v3        <= v2;
      if (out_free) out_valid <= v3;
    end
  end

  // decimal split, one digit per stage
  assign q1 = div10(s1_res.remaining);
  assign q2 = div10(TIME_W'(s2_q));
  assign q3 = div10(TIME_W'(s3_q));
  assign d3 = (q3[4:0] >= 5'd10) ? 4'(q3[4:0] - 5'd10) : q3[3:0];

  // stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res.heater    <= heater_reg_next;
      s1_res.eject     <= eject_reg_next;
      s1_res.run       <= run_flag_next;
      s1_res.toast     <= toast_flag_next;
      s1_res.message   <= message_reg_next;
      s1_res.remaining <= count_left_next;
    end
    if (rdy2 && v1) begin
      s2_res <= s1_res;
      s2_q   <= q1;
      s2_d0  <= rem10(s1_res.remaining, q1);
    end
    if (rdy3 && v2) begin
      s3_res <= s2_res;
      s3_q   <= q2[7:0];
      s3_d0  <= s2_d0;
      s3_d1  <= rem10(TIME_W'(s2_q), q2);
    end
    if (out_free && v3) begin
      heater_on <= s3_res.heater;
      eject_on  <= s3_res.eject;
      running   <= s3_res.run;
      toasting  <= s3_res.toast;
      message   <= s3_res.message;
      remaining <= s3_res.remaining;
      segments  <= {seg7(d3), seg7(rem10(TIME_W'(s3_q), q3)), seg7(s3_d1), seg7(s3_d0)};
    end
  end

endmodule

// ----- bench/tb_toast_cycle_controller.sv -----
import tcc_pkg::*;

// Sensor bits as the block holds them
localparam logic [3:0] SENSE_BREAD = 4'b0001;
localparam logic [3:0] SENSE_ERROR = 4'b0010;
localparam logic [3:0] SENSE_HOT   = 4'b0100;
localparam logic [3:0] SENSE_BURNT = 4'b1000;

// One event beat as accepted on the input channel
typedef struct packed {
  logic [1:0] command;
  logic [2:0] level;
  logic [3:0] sensors;  // {burnt, overheat, fault_error, bread_present}
  logic [1:0] key;
} toast_event_t;

// One status beat on the result channel
typedef struct packed {
  logic              heater;
  logic              eject;
  logic              run;
  logic              toast;
  logic [MSG_W-1:0]  message;
  logic [TIME_W-1:0] remaining;
  logic [SEG_W-1:0]  segments;
} toast_status_t;

// Toaster state tracker and queue of predicted status beats
class toast_scoreboard;
  logic [TIME_W-1:0] level_secs [NUM_LEVELS];
  bit                run_q, stop_q, toast_q, resume_q, heat_q, eject_q;
  logic [14:0]       count_q, cycle_q;
  logic [2:0]        level_q;
  logic [3:0]        sense_q;
  logic [MSG_W-1:0]  msg_q;
  toast_status_t     expected_q [$];
  int                errors;

  function new();
    level_secs[0] = 14'd12;
    level_secs[1] = 14'd25;
    level_secs[2] = 14'd40;
    level_secs[3] = 14'd60;
    level_secs[4] = 14'd70;
    run_q    = 1'b0;
    stop_q   = 1'b1;
    toast_q  = 1'b0;
    resume_q = 1'b0;
    heat_q   = 1'b0;
    eject_q  = 1'b0;
    count_q  = '0;
    cycle_q  = '0;
    level_q  = '0;
    sense_q  = '0;
    msg_q    = MSG_IDLE;
    errors   = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("mismatch: %s", what);
  endtask

  function void halt_heating();
    run_q   = 1'b0;
    stop_q  = 1'b1;
    toast_q = 1'b0;
    heat_q  = 1'b0;
  endfunction

  function logic [7:0] digit_pattern(int d);
    logic [7:0] pats [10];
    pats = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67};
    return pats[d];
  endfunction

  // Advance the tracked state by one event and queue the status it gives
  function void note_event(toast_event_t ev);
    toast_status_t st;
    int            v;
    case (ev.command)
      CMD_TICK: begin
        if (toast_q && level_q < LEVEL_CONT && count_q != 0) count_q = count_q - 15'd1;
      end
      CMD_SWITCH: begin
        sense_q = ev.sensors;
        // time is latched only on a level change
        if (ev.level != level_q) begin
          level_q = ev.level;
          if (ev.level >= 3'd1 && ev.level <= 3'd5) begin
            cycle_q = 15'(level_secs[ev.level - 3'd1]);
          end else begin
            cycle_q = '0;
          end
        end
      end
      CMD_KEY: begin
        case (ev.key)
          KEY_START: begin
            if ((sense_q & SENSE_BREAD) != 0 && (sense_q & (SENSE_ERROR | SENSE_HOT)) == 0 &&
                level_q != 0) begin
              run_q   = 1'b1;
              stop_q  = 1'b0;
              toast_q = 1'b1;
              count_q = (level_q >= LEVEL_CONT) ? 15'd0 : cycle_q;
              heat_q  = 1'b1;
              eject_q = 1'b0;
              msg_q   = MSG_TOASTING;
            end
          end
          KEY_STOP: begin
            halt_heating();
            count_q = '0;
            eject_q = 1'b1;
            msg_q   = MSG_STOPPED;
          end
          KEY_PAUSE: begin
            run_q  = 1'b1;
            stop_q = 1'b0;
            if (toast_q) begin
              toast_q  = 1'b0;
              resume_q = 1'b0;
              heat_q   = 1'b0;
              msg_q    = MSG_PAUSED;
            end else begin
              toast_q  = 1'b1;
              resume_q = 1'b1;
              heat_q   = 1'b1;
              msg_q    = MSG_TOASTING;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // sensor faults first, then the end of a timed cycle
    if (run_q) begin
      if ((sense_q & SENSE_BREAD) == 0 || (sense_q & (SENSE_ERROR | SENSE_HOT | SENSE_BURNT)) != 0)
      begin
        halt_heating();
        eject_q = 1'b1;
        if ((sense_q & SENSE_BURNT) != 0)      msg_q = MSG_BURNT;
        else if ((sense_q & SENSE_HOT) != 0)   msg_q = MSG_OVERHEAT;
        else if ((sense_q & SENSE_ERROR) != 0) msg_q = MSG_ERROR;
        else                                   msg_q = MSG_NOBREAD;
      end else if (count_q == 0 && level_q < LEVEL_CONT) begin
        halt_heating();
        msg_q = MSG_FINISHED;
      end
    end

    v = int'(count_q[13:0]);
    st.heater    = heat_q;
    st.eject     = eject_q;
    st.run       = run_q;
    st.toast     = toast_q;
    st.message   = msg_q;
    st.remaining = count_q[13:0];
    st.segments  = {digit_pattern((v / 1000) % 10), digit_pattern((v / 100) % 10),
                    digit_pattern((v / 10) % 10), digit_pattern(v % 10)};
    expected_q.push_back(st);
  endfunction

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task check_result(toast_status_t got);
    toast_status_t want;
    if (expected_q.size() == 0) begin
      report("status beat with no event pending");
      return;
    end
    want = expected_q.pop_front();
    compare_field("heater_on", 32'(got.heater), 32'(want.heater));
    compare_field("eject_on", 32'(got.eject), 32'(want.eject));
    compare_field("running", 32'(got.run), 32'(want.run));
    compare_field("toasting", 32'(got.toast), 32'(want.toast));
    compare_field("message", 32'(got.message), 32'(want.message));
    compare_field("remaining", 32'(got.remaining), 32'(want.remaining));
    compare_field("segments", got.segments, want.segments);
  endtask
endclass

module tb_toast_cycle_controller;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = '0;
  logic [2:0]        level = '0;
  logic              bread_present = 1'b0;
  logic              fault_error = 1'b0;
  logic              overheat = 1'b0;
  logic              burnt = 1'b0;
  logic [1:0]        key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              heater_on;
  logic              eject_on;
  logic              running;
  logic              toasting;
  logic [MSG_W-1:0]  message;
  logic [TIME_W-1:0] remaining;
  logic [SEG_W-1:0]  segments;

  toast_scoreboard sb = new();
  int              send_idle = 0;
  int              recv_stall = 0;
  int              items_sent = 0;

  toast_cycle_controller u_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver backpressure
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin : monitor
    toast_event_t  ev;
    toast_status_t st;
    if (!rst) begin
      if (in_valid && in_ready) begin
        ev.command = command;
        ev.level   = level;
        ev.sensors = {burnt, overheat, fault_error, bread_present};
        ev.key     = key;
        sb.note_event(ev);
      end
      if (out_valid && out_ready) begin
        st.heater    = heater_on;
        st.eject     = eject_on;
        st.run       = running;
        st.toast     = toasting;
        st.message   = message;
        st.remaining = remaining;
        st.segments  = segments;
        sb.check_result(st);
      end
    end
  end

  // one event beat, with a random gap in front
  task send_event(logic [1:0] cmd, logic [2:0] lvl, logic [3:0] sens, logic [1:0] k);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    level         <= lvl;
    bread_present <= sens[0];
    fault_error   <= sens[1];
    overheat      <= sens[2];
    burnt         <= sens[3];
    key           <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task send_tick();
    send_event(CMD_TICK, 3'($urandom), 4'($urandom), 2'($urandom));
  endtask

  task send_key(logic [1:0] k);
    send_event(CMD_KEY, 3'($urandom), 4'($urandom), k);
  endtask

  task send_switch(logic [2:0] lvl, logic [3:0] sens);
    send_event(CMD_SWITCH, lvl, sens, 2'($urandom));
  endtask

  // hold the sender until every status beat is back
  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task apb_access(bit wr, logic [2:0] idx, logic [DATA_W-1:0] wdata,
                  output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a level time (junk above bit 13) and read it back
  task write_level(logic [2:0] idx, logic [TIME_W-1:0] secs);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, idx, {18'($urandom), secs}, rd);
    sb.level_secs[idx] = secs;
    apb_access(1'b0, idx, DATA_W'($urandom), rd);
    if (rd !== DATA_W'(secs))
      sb.report($sformatf("level register %0d read %0h expected %0h", idx, rd, secs));
  endtask

  // a clean start followed by a random run of events
  task toast_session();
    int r;
    send_switch(3'($urandom_range(1, 7)), SENSE_BREAD);
    send_key(KEY_START);
    repeat ($urandom_range(2, 30)) begin
      r = $urandom_range(99);
      if (r < 60)      send_tick();
      else if (r < 70) send_key(KEY_PAUSE);
      else if (r < 76) send_switch(3'($urandom), SENSE_BREAD);
      else if (r < 82) send_switch(3'($urandom), 4'($urandom));
      else if (r < 87) send_key(KEY_STOP);
      else if (r < 92) send_key(KEY_START);
      else if (r < 95) send_event(2'd3, 3'($urandom), 4'($urandom), 2'($urandom));
      else             send_key(2'd3);
    end
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] secs [NUM_LEVELS];
    int                target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset level times
    send_tick();                                  // tick with count already zero
    send_key(KEY_START);                          // no bread
    send_switch(3'd0, SENSE_BREAD);
    send_key(KEY_START);                          // level zero
    send_switch(3'd1, SENSE_BREAD | SENSE_ERROR);
    send_key(KEY_START);                          // fault
    send_switch(3'd1, SENSE_BREAD | SENSE_HOT);
    send_key(KEY_START);                          // overheat
    send_switch(3'd1, SENSE_BREAD | SENSE_BURNT);
    send_key(KEY_START);                          // burnt: starts, ends at once
    send_switch(3'd2, SENSE_BREAD);
    send_key(KEY_START);
    send_tick();
    send_key(KEY_PAUSE);
    send_tick();                                  // paused, no countdown
    send_key(KEY_PAUSE);
    send_switch(3'd3, SENSE_BREAD);               // level change mid-cycle
    send_tick();
    send_key(KEY_STOP);
    send_key(KEY_PAUSE);                          // continue from idle, finishes at zero
    send_switch(3'd7, SENSE_BREAD);
    send_key(KEY_START);                          // continuous
    send_tick();
    send_switch(3'd5, SENSE_BREAD);               // continuous to timed at zero
    send_key(KEY_START);
    send_switch(3'd5, '0);                        // bread removed
    send_event(2'd3, 3'd7, 4'hF, 2'd3);           // unknown command
    send_key(2'd3);                               // unknown key
    send_switch(3'd7, 4'hF);
    drain_results();

    // random phases, each with its own level times and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: secs = '{14'd0, 14'd9999, 14'd1, 14'd5, 14'd3};
        2: secs = '{14'd9999, 14'd0, 14'd2, 14'd9999, 14'd1};
        default: foreach (secs[i]) secs[i] = TIME_W'($urandom_range(0, 20));
      endcase
      foreach (secs[i]) write_level(REG_LEVEL_ONE + 3'(i), secs[i]);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 76; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 76; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      target = items_sent + 360;
      while (items_sent < target) begin
        if ($urandom_range(99) < 80) begin
          toast_session();
        end else begin
          send_event(2'($urandom), 3'($urandom), 4'($urandom), 2'($urandom));
        end
        if ($urandom_range(99) < 2) drain_results();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 600000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
